[sv/sha256_pkg.sv]
package sha256_pkg;

	typedef logic [7:0][31:0] hash_t;

	// control from the sequencer to the schedule window and the round unit
	typedef struct packed {
		logic       push;
		logic [7:0] pbyte;
		logic       start;
		logic       round;
		logic [5:0] rnd;
	} core_ctrl_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] PAD_LEN_AT  = 6'd56;
	localparam logic [5:0] FILL_LAST   = 6'd63;
	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [2:0] LAST_IDX    = 3'd7;

	// element 0 is the first chaining word
	localparam hash_t IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

[sv/sha256_sched.sv]
module sha256_sched (
	input  logic                    clk,
	input  sha256_pkg::core_ctrl_t  ctrl,
	output logic [31:0]             w_t
);

	// 16-word window, word 0 (msbs) is the oldest; bytes shift in at the bottom
	logic [511:0] win_q;
	logic [31:0]  w0, w1, w9, w14, w_new;

	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];

	assign w_new = sha256_pkg::ssig1(w14) + w9 + sha256_pkg::ssig0(w1) + w0;
	assign w_t   = w0;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q <= {win_q[503:0], ctrl.pbyte};
		end else if (ctrl.round) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

[sv/sha256_round.sv]
module sha256_round (
	input  logic                    clk,
	input  sha256_pkg::core_ctrl_t  ctrl,
	input  sha256_pkg::hash_t       chain,
	input  logic [31:0]             w_t,
	output sha256_pkg::hash_t       v
);

	sha256_pkg::hash_t v_q;
	logic [31:0] t1, t2, ch, mj;

	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ch
		+ sha256_pkg::ROUND_K[ctrl.rnd] + w_t;
	assign t2 = sha256_pkg::bsig0(v_q[0]) + mj;
	assign v  = v_q;

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			v_q <= chain;
		end else if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

[sv/sha256_stream_hasher.sv]
// SHA-256 over a byte stream.
// Input channel (in_valid/in_stall): op = absorb takes data_byte as the next
// message byte, op = finish pads the message and produces its digest.
// Output channel (out_valid/out_stall): eight words, word_index 0..7, each
// digest_word most significant byte first, last_word set on index 7.
// An absorb byte is pushed as it is accepted; the one that completes a 64-byte
// block then runs 64 rounds of the shared round unit and one chain update.
// A finish pushes the padding one byte per cycle while no block is compressing
// (9 to 72 bytes); each of the one or two blocks it completes then runs 64
// rounds and one chain update. It then presents the digest, one
// word per cycle while out_stall is low. in_stall stays high from the cycle
// after an accepted finish or block-completing byte until it is back in idle.
// A stalled digest word holds its value until taken. After the last word the
// chaining value returns to the initial hash and the length count clears.
// Reset loads the initial hash, clears the byte count and fill level and
// leaves the block idle; there is no clearing pass.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_COMP  = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t                 st_q;
	logic [5:0]             fill_q;
	logic [60:0]            count_q;
	sha256_pkg::hash_t      chain_q;
	logic [5:0]             rnd_q;
	logic                   pad_q, mark_q, len_q, emit_q;
	logic [2:0]             idx_q;
	logic [63:0]            len_sr_q;
	logic [2:0]             oidx_q;

	sha256_pkg::core_ctrl_t ctrl;
	sha256_pkg::hash_t      v;
	logic [31:0]            w_t;
	logic                   in_acc, len_push, wrap;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign len_push = !mark_q && (len_q || fill_q == sha256_pkg::PAD_LEN_AT);

	always_comb begin
		ctrl = '0;
		ctrl.pbyte = data_byte;
		if (st_q == ST_IDLE && in_acc && op == sha256_pkg::OP_ABSORB) begin
			ctrl.push = 1'b1;
		end
		if (st_q == ST_PAD) begin
			ctrl.push = 1'b1;
			if (mark_q) begin
				ctrl.pbyte = sha256_pkg::PAD_MARK;
			end else if (len_push) begin
				ctrl.pbyte = len_sr_q[63:56];
			end else begin
				ctrl.pbyte = 8'h00;
			end
		end
		ctrl.round = (st_q == ST_COMP);
		ctrl.rnd   = rnd_q;
		ctrl.start = ctrl.push && fill_q == sha256_pkg::FILL_LAST;
	end

	assign wrap = ctrl.start;

	sha256_sched u_sched (
		.clk  (clk),
		.ctrl (ctrl),
		.w_t  (w_t)
	);

	sha256_round u_round (
		.clk   (clk),
		.ctrl  (ctrl),
		.chain (chain_q),
		.w_t   (w_t),
		.v     (v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			fill_q   <= '0;
			count_q  <= '0;
			chain_q  <= sha256_pkg::IV;
			rnd_q    <= '0;
			pad_q    <= 1'b0;
			mark_q   <= 1'b0;
			len_q    <= 1'b0;
			emit_q   <= 1'b0;
			idx_q    <= '0;
			len_sr_q <= '0;
			oidx_q   <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == sha256_pkg::OP_ABSORB) begin
							fill_q  <= fill_q + 6'd1;
							count_q <= count_q + 61'd1;
							if (wrap) begin
								rnd_q <= '0;
								st_q  <= ST_COMP;
							end
						end else begin
							len_sr_q <= {count_q, 3'b000};
							pad_q    <= 1'b1;
							mark_q   <= 1'b1;
							len_q    <= 1'b0;
							emit_q   <= 1'b0;
							idx_q    <= '0;
							st_q     <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					mark_q <= 1'b0;
					// length field goes out msb first after the zero fill
					if (len_push) begin
						len_q    <= 1'b1;
						len_sr_q <= {len_sr_q[55:0], 8'h00};
						idx_q    <= idx_q + 3'd1;
						if (idx_q == sha256_pkg::LAST_IDX) begin
							emit_q <= 1'b1;
						end
					end
					if (wrap) begin
						rnd_q <= '0;
						st_q  <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == sha256_pkg::LAST_ROUND) begin
						st_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v[i];
					end
					if (emit_q) begin
						oidx_q <= '0;
						st_q   <= ST_OUT;
					end else if (pad_q) begin
						st_q <= ST_PAD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == sha256_pkg::LAST_IDX) begin
							chain_q <= sha256_pkg::IV;
							fill_q  <= '0;
							count_q <= '0;
							pad_q   <= 1'b0;
							emit_q  <= 1'b0;
							len_q   <= 1'b0;
							st_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = (st_q == ST_OUT);
	assign digest_word = chain_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == sha256_pkg::LAST_IDX);

	a_no_input_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while digest pending");

	a_rounds_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COMP && $past(st_q) != ST_COMP) |-> rnd_q == 6'd0)
		else $error("compression entered with nonzero round count");

	a_emit_on_block_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FINAL && emit_q) |-> (fill_q == 6'd0 && idx_q == 3'd0))
		else $error("digest ready with partial padding");

	a_clear_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=>
			(fill_q == 6'd0 && count_q == 61'd0 && !out_valid))
		else $error("state not cleared after last digest word");

endmodule
